### hdl/rpast_pkg.sv
// Shared types and constants for the range progression add / sum tree.
// Used by range_progression_add_sum_tree_unit; no dependencies.
`default_nettype none

package rpast_pkg;

	localparam int VALUE_BITS       = 32;
	localparam int IDX_BITS         = 10;
	localparam int COUNT_BITS       = 11;
	localparam int DEF_MAX_ELEMENTS = 1024;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	// lazy tags of one node: first term and step still owed to its span
	typedef struct packed {
		logic [VALUE_BITS-1:0] f;
		logic [VALUE_BITS-1:0] s;
	} tag_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ENTER,
		ST_TAG,
		ST_SUM,
		ST_CHB,
		ST_STEP,
		ST_UP0,
		ST_UP1,
		ST_UP2,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

### hdl/range_progression_add_sum_tree_unit.sv
// Range progression add / range sum unit: lazy segment tree over on-chip memories.
// Depends on rpast_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command item: load one element,
//   add slope*(p-lo+1)+offset over lo..hi, or query the wrapped sum over lo..hi.
//   Output channel (out_valid / out_stall) returns one range_sum item per query.
//   cfg_valid / cfg_ready writes element_count; every write also clears the tree.
//   The tree is a fixed power-of-two heap, 2**ceil(log2(MAX_ELEMENTS)) leaves,
//   walked depth first by one sequencer with one multiplier and shift-and-add logic.
//   Each visited node passes through ENTER, TAG, SUM and CHB (CHB is skipped at
//   a leaf) and then STEP; each partially covered node passes through UP0, UP1
//   and UP2 on the way up for loads and adds. A command visits up to about
//   4*log2(leaves) nodes. Ignored commands and empty ranges go from IDLE to FIN.
//   One item is in flight at a time; in_stall is high until it is finished.
//   After reset and after each configuration write a clearing pass over all
//   2*2**ceil(log2(MAX_ELEMENTS)) entries (2048 by default) runs with in_stall high.
//   A finished query waits in the output register while out_stall is high; the
//   sequencer holds in its final state until that register is free.
`default_nettype none

module range_progression_add_sum_tree_unit
	import rpast_pkg::*;
#(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   command,
	input  wire logic [IDX_BITS-1:0]          index_lo,
	input  wire logic [IDX_BITS-1:0]          index_hi,
	input  wire logic signed [VALUE_BITS-1:0] slope,
	input  wire logic signed [VALUE_BITS-1:0] offset,
	input  wire logic signed [VALUE_BITS-1:0] load_value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [VALUE_BITS-1:0]      range_sum,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [COUNT_BITS-1:0]        cfg_data
);

	localparam int VB    = VALUE_BITS;
	localparam int L     = $clog2(MAX_ELEMENTS);
	localparam int AW    = L + 1;
	localparam int DEPTH = 2 ** AW;
	localparam int DW    = $clog2(L + 1);
	localparam int UW    = (L + 1 > COUNT_BITS) ? L + 1 : COUNT_BITS;
	localparam int PW    = (L > IDX_BITS) ? L : IDX_BITS;
	localparam logic [DW-1:0] LEAF_D = DW'(L);
	localparam logic [UW-1:0] MAX_U  = UW'(MAX_ELEMENTS);

	state_t state_q, state_d;

	logic [UW-1:0]  count_q;
	logic [AW-1:0]  clr_q;
	logic           out_valid_q;
	logic           acc_pend_q;
	logic [VB-1:0]  range_sum_q;

	logic [1:0]     cmd_q;
	logic [L-1:0]   a_q, b_q;
	logic [VB-1:0]  slope_q, offset_q, load_q;
	logic [AW-1:0]  k_q;
	logic [DW-1:0]  d_q;
	logic [VB-1:0]  acc_q, ns_q, f_q, s_q, sum_q, sum_lo_q, prod_q;
	logic           cover_q, disj_q;

	// memories
	logic [VB-1:0]  sum_mem [DEPTH];
	tag_t           tag_mem [DEPTH];
	logic [VB-1:0]  sum_rd;
	tag_t           tag_rd;
	logic           sum_we, tag_we;
	logic [AW-1:0]  sum_wa, sum_ra, tag_wa, tag_ra;
	logic [VB-1:0]  sum_wd;
	tag_t           tag_wd;

	logic in_acc, cfg_acc, out_free, load_out;

	// range clamp
	logic [UW-1:0] used_c, last_c;
	logic [PW-1:0] lo_p, hi_p, last_p, hi_cl;
	logic          go_c;

	// node geometry
	logic [DW-1:0] sh;
	logic [AW-1:0] ksh, child_a, child_b, diff;
	logic [L-1:0]  node_lo, node_hi, span_mask;
	logic          leaf, disj_c, cover_c;
	logic [VB-1:0] prod_c, t_len, t_s, t_tri, s_half, ns_c;

	assign in_acc   = in_valid && !in_stall;
	assign cfg_acc  = cfg_valid && cfg_ready;
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == ST_FIN) && (cmd_q == CMD_QUERY) && out_free;

	assign used_c = (count_q == '0) ? UW'(1) : ((count_q > MAX_U) ? MAX_U : count_q);
	assign last_c = used_c - UW'(1);
	assign lo_p   = PW'(index_lo);
	assign hi_p   = PW'(index_hi);
	assign last_p = PW'(last_c[L-1:0]);
	assign hi_cl  = (hi_p > last_p) ? last_p : hi_p;

	always_comb begin
		case (command)
			CMD_LOAD:  go_c = (lo_p <= last_p);
			CMD_ADD:   go_c = (lo_p <= hi_cl);
			CMD_QUERY: go_c = (lo_p <= hi_cl);
			default:   go_c = 1'b0;
		endcase
	end

	// node k at depth d spans [(k-2^d) << sh, +2^sh-1], sh = L-d
	assign sh        = LEAF_D - d_q;
	assign ksh       = k_q << sh;
	assign node_lo   = ksh[L-1:0];
	assign span_mask = L'((AW'(1) << sh) - AW'(1));
	assign node_hi   = node_lo | span_mask;
	assign leaf      = (d_q == LEAF_D);
	assign child_a   = {k_q[L-1:0], 1'b0};
	assign child_b   = {k_q[L-1:0], 1'b1};
	assign disj_c    = (node_lo > b_q) || (node_hi < a_q);
	assign cover_c   = (a_q <= node_lo) && (node_hi <= b_q);
	assign diff      = {1'b0, node_lo} - {1'b0, a_q} + AW'(1);
	assign prod_c    = slope_q * VB'(diff);

	// len*f + len*(len-1)/2*s with len = 2^sh
	assign t_len  = f_q << sh;
	assign t_s    = (s_q << sh) - s_q;
	assign t_tri  = (sh == '0) ? '0 : (t_s << (sh - DW'(1)));
	assign s_half = (sh == '0) ? '0 : (s_q << (sh - DW'(1)));
	assign ns_c   = sum_q + t_len + t_tri;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE:  if (in_acc) state_d = go_c ? ST_ENTER : ST_FIN;
			ST_ENTER: state_d = ST_TAG;
			ST_TAG:   state_d = ST_SUM;
			ST_SUM:   state_d = leaf ? ST_STEP : ST_CHB;
			ST_CHB:   state_d = (!disj_q && !cover_q) ? ST_ENTER : ST_STEP;
			ST_STEP: begin
				if (k_q == AW'(1))
					state_d = ST_FIN;
				else if (!k_q[0])
					state_d = ST_ENTER;
				else
					state_d = (cmd_q == CMD_QUERY) ? ST_STEP : ST_UP0;
			end
			ST_UP0:   state_d = ST_UP1;
			ST_UP1:   state_d = ST_UP2;
			ST_UP2:   state_d = ST_STEP;
			ST_FIN:   if (cmd_q != CMD_QUERY || out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
		if (cfg_acc)
			state_d = ST_CLEAR;
	end

	// outputs and memory controls
	assign in_stall  = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign range_sum = range_sum_q;

	always_comb begin
		sum_we = 1'b0;
		sum_wa = k_q;
		sum_wd = ns_c;
		sum_ra = k_q;
		tag_we = 1'b0;
		tag_wa = k_q;
		tag_wd = '0;
		tag_ra = k_q;
		case (state_q)
			ST_CLEAR: begin
				sum_we = 1'b1;
				sum_wa = clr_q;
				sum_wd = '0;
				tag_we = 1'b1;
				tag_wa = clr_q;
			end
			ST_TAG: begin
				tag_we = 1'b1;
				tag_ra = child_a;
			end
			ST_SUM: begin
				sum_we = 1'b1;
				if (cmd_q == CMD_LOAD && cover_q)
					sum_wd = load_q;
				tag_we   = !leaf;
				tag_wa   = child_a;
				tag_wd.f = tag_rd.f + f_q;
				tag_wd.s = tag_rd.s + s_q;
				tag_ra   = child_b;
			end
			ST_CHB: begin
				tag_we   = 1'b1;
				tag_wa   = child_b;
				tag_wd.f = tag_rd.f + f_q + s_half;
				tag_wd.s = tag_rd.s + s_q;
			end
			ST_UP0: sum_ra = child_a;
			ST_UP1: sum_ra = child_b;
			ST_UP2: begin
				sum_we = 1'b1;
				sum_wd = sum_lo_q + sum_rd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sum_we)
			sum_mem[sum_wa] <= sum_wd;
		sum_rd <= sum_mem[sum_ra];
	end

	always_ff @(posedge clk) begin
		if (tag_we)
			tag_mem[tag_wa] <= tag_wd;
		tag_rd <= tag_mem[tag_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			count_q     <= MAX_U;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			acc_pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				count_q <= UW'(cfg_data);
				clr_q   <= '0;
			end else if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (load_out)
				out_valid_q <= 1'b1;
			acc_pend_q <= (state_q == ST_SUM) && (cmd_q == CMD_QUERY) && cover_q;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc_pend_q)
			acc_q <= acc_q + ns_q;
		if (load_out)
			range_sum_q <= acc_q;
		case (state_q)
			ST_IDLE: begin
				cmd_q    <= command;
				a_q      <= lo_p[L-1:0];
				b_q      <= (command == CMD_LOAD) ? lo_p[L-1:0] : hi_cl[L-1:0];
				slope_q  <= slope;
				offset_q <= offset;
				load_q   <= load_value;
				k_q      <= AW'(1);
				d_q      <= '0;
				acc_q    <= '0;
			end
			ST_ENTER: begin
				prod_q  <= prod_c;
				cover_q <= cover_c;
				disj_q  <= disj_c;
			end
			ST_TAG: begin
				// pending tags plus, on a covered node of an add, the new progression
				if (cmd_q == CMD_ADD && cover_q) begin
					f_q <= tag_rd.f + offset_q + prod_q;
					s_q <= tag_rd.s + slope_q;
				end else begin
					f_q <= tag_rd.f;
					s_q <= tag_rd.s;
				end
				sum_q <= sum_rd;
			end
			ST_SUM: ns_q <= ns_c;
			ST_CHB: begin
				if (!disj_q && !cover_q) begin
					k_q <= child_a;
					d_q <= d_q + DW'(1);
				end
			end
			ST_STEP: begin
				if (k_q != AW'(1)) begin
					if (!k_q[0]) begin
						k_q <= k_q + AW'(1);
					end else begin
						k_q <= k_q >> 1;
						d_q <= d_q - DW'(1);
					end
				end
			end
			ST_UP1: sum_lo_q <= sum_rd;
			default: begin
			end
		endcase
	end

	// checks
	a_node_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENTER) |-> ((k_q >> d_q) == AW'(1)))
		else $error("node index does not match depth");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENTER) |-> (a_q <= b_q))
		else $error("range bounds out of order during walk");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN && cmd_q == CMD_QUERY))
		else $error("result item raised outside a finished query");

	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && clr_q == '1 && !cfg_valid) |=> (state_q == ST_IDLE))
		else $error("clearing pass did not end");

endmodule

`default_nettype wire
